// ----- design/poa_pkg.sv -----
// shared types and constants for the priority ownership arbiter
`default_nettype none

package poa_pkg;

    localparam int MODULE_BITS = 16;
    localparam int HOLD_BITS   = 8;
    localparam int TYPE_BITS   = 3;
    localparam int STATUS_BITS = 2;

    localparam logic [HOLD_BITS-1:0] HOLD_RESET = 8'd20;

    localparam logic [TYPE_BITS-1:0] REQ_REQUEST  = 3'd0;
    localparam logic [TYPE_BITS-1:0] REQ_RELEASE  = 3'd1;
    localparam logic [TYPE_BITS-1:0] REQ_TICK     = 3'd2;
    localparam logic [TYPE_BITS-1:0] REQ_SUPPRESS = 3'd3;
    localparam logic [TYPE_BITS-1:0] REQ_ENABLE   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_SUPPRESSED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_HIGHER     = 2'd2;

    typedef logic [MODULE_BITS-1:0] module_id_t;
    typedef logic [HOLD_BITS-1:0]   hold_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0] req_type;
        module_id_t           module_id;
    } item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        module_id_t             current_owner;
        logic                   was_owner;
    } result_t;

endpackage

`default_nettype wire

// ----- design/poa_in_stage.sv -----
// input register stage holding one accepted request beat
`default_nettype none

module poa_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire poa_pkg::item_t in_item,
    output logic               item_valid,
    output poa_pkg::item_t     item,
    input  wire logic          advance
);
    import poa_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- design/poa_engine.sv -----
// ownership state and the per-beat arbitration logic
`default_nettype none

module poa_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire poa_pkg::hold_t   cfg_wr_data,
    input  wire logic             fire,
    input  wire poa_pkg::item_t   item,
    output poa_pkg::result_t      result
);
    import poa_pkg::*;

    hold_t      hold_ticks_reg;
    module_id_t owner_reg;
    module_id_t owner_next;
    module_id_t mask_reg;
    module_id_t mask_next;
    hold_t      timer_reg;
    hold_t      timer_next;
    module_id_t lapsed_owner;
    logic [STATUS_BITS-1:0] status;
    module_id_t mod;

    assign mod = item.module_id;

    always_comb
    begin
        owner_next   = owner_reg;
        mask_next    = mask_reg;
        timer_next   = timer_reg;
        status       = ST_OK;
        lapsed_owner = (timer_reg == '0) ? '0 : owner_reg;
        unique case (item.req_type)
            REQ_REQUEST:
            begin
                if (mod == owner_reg)
                begin
                    timer_next = hold_ticks_reg;
                end
                else
                begin
                    owner_next = lapsed_owner;
                    if ((mask_reg & mod) != '0)
                    begin
                        status = ST_SUPPRESSED;
                    end
                    else if (mod < lapsed_owner)
                    begin
                        status = ST_HIGHER;
                    end
                    else if (mod > lapsed_owner)
                    begin
                        owner_next = mod;
                        timer_next = hold_ticks_reg;
                    end
                end
            end
            REQ_RELEASE:
            begin
                if (mod < owner_reg)
                begin
                    status = ST_HIGHER;
                end
                else
                begin
                    owner_next = '0;
                end
            end
            REQ_TICK:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - hold_t'(1);
                end
            end
            REQ_SUPPRESS:
            begin
                if (owner_reg == mod)
                begin
                    owner_next = '0;
                end
                mask_next = mask_reg | mod;
            end
            REQ_ENABLE:
            begin
                mask_next = mask_reg & ~mod;
            end
            default:
            begin
            end
        endcase
    end

    assign result.status        = status;
    assign result.current_owner = owner_next;
    assign result.was_owner     = ((mask_reg & mod) == '0) && (mod == owner_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_RESET;
            owner_reg      <= '0;
            mask_reg       <= '0;
            timer_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hold_ticks_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                owner_reg <= owner_next;
                mask_reg  <= mask_next;
                timer_reg <= timer_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/poa_out_stage.sv -----
// result register toward the output channel
`default_nettype none

module poa_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire poa_pkg::result_t load_result,
    output logic                  can_load,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output poa_pkg::result_t      out_result
);
    import poa_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ----- design/priority_ownership_arbiter_core.sv -----
// top level of the priority ownership arbiter
//
// request beats (req_type, module_id) enter on in_valid/in_ready; every beat
// produces exactly one result beat (status, current_owner, was_owner) on
// out_valid/out_ready, in order.
// hold_ticks is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while idle, the block does not enforce it. An accepted beat passes
// the input register, then the arbitration logic into the result register.
// throughput: one beat per cycle while out_ready is high; owner, mask and
// hold timer update in the same cycle that the result is loaded, so
// back-to-back beats see each other's effects.
// reset: no owner, nothing masked, hold timer zero, hold_ticks 20, both
// pipeline registers empty.
// stall: when out_ready is low the result register holds its beat, the input
// register then fills, and in_ready drops until the result beat is taken.
`default_nettype none

module priority_ownership_arbiter_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [poa_pkg::HOLD_BITS-1:0]         cfg_wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [poa_pkg::TYPE_BITS-1:0]         req_type,
    input  wire logic [poa_pkg::MODULE_BITS-1:0]       module_id,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [poa_pkg::STATUS_BITS-1:0]            status,
    output logic [poa_pkg::MODULE_BITS-1:0]            current_owner,
    output logic                                       was_owner
);
    import poa_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t out_result;

    assign in_item.req_type  = req_type;
    assign in_item.module_id = module_id;
    assign fire              = item_valid && can_load;

    poa_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (can_load)
    );

    poa_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .result      (result)
    );

    poa_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .load_result (result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign status        = out_result.status;
    assign current_owner = out_result.current_owner;
    assign was_owner     = out_result.was_owner;

endmodule

`default_nettype wire

// ----- bench/priority_ownership_arbiter_core_test.sv -----
// testbench for the priority ownership arbiter core: ownership scoreboard and stimulus
module priority_ownership_arbiter_core_test;

    import poa_pkg::*;

    localparam logic [TYPE_BITS-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [TYPE_BITS-1:0] REQ_SPARE_LAST  = 3'd7;
    localparam int PHASE_BEATS  = 125;
    localparam int LONG_STALL   = 150;
    localparam int CYCLE_LIMIT  = 500000;

    class ownership_tracker;
        hold_t      hold_ticks;
        hold_t      timer;
        module_id_t owner;
        module_id_t mask;
        result_t    owed[$];
        int         errors;

        function new();
            hold_ticks = HOLD_RESET;
            timer      = '0;
            owner      = '0;
            mask       = '0;
            errors     = 0;
        endfunction

        function void set_hold(hold_t v);
            hold_ticks = v;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_item(logic [TYPE_BITS-1:0] kind, module_id_t mod);
            result_t r;
            r.status    = ST_OK;
            r.was_owner = ((mask & mod) == '0) && (mod == owner);
            case (kind)
                REQ_REQUEST:
                begin
                    if (mod == owner)
                    begin
                        timer = hold_ticks;
                    end
                    else
                    begin
                        // lapsed owner is dropped before the checks
                        if (timer == '0 && owner != '0)
                            owner = '0;
                        if ((mask & mod) != '0)
                            r.status = ST_SUPPRESSED;
                        else if (mod < owner)
                            r.status = ST_HIGHER;
                        else if (mod > owner)
                        begin
                            owner = mod;
                            timer = hold_ticks;
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    if (mod < owner)
                        r.status = ST_HIGHER;
                    else
                        owner = '0;
                end
                REQ_TICK:
                begin
                    if (timer != '0)
                        timer = timer - 1'b1;
                end
                REQ_SUPPRESS:
                begin
                    if (owner == mod)
                        owner = '0;
                    mask = mask | mod;
                end
                REQ_ENABLE:
                begin
                    mask = mask & ~mod;
                end
                default:
                begin
                end
            endcase
            r.current_owner = owner;
            owed.push_back(r);
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] st, module_id_t cur, logic was);
            result_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, status %0d owner %h",
                         $time, st, cur);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (cur !== want.current_owner)
            begin
                $display("%0t: current_owner expected %h actual %h",
                         $time, want.current_owner, cur);
                errors++;
            end
            if (was !== want.was_owner)
            begin
                $display("%0t: was_owner expected %0d actual %0d", $time, want.was_owner, was);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    hold_t                  cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [TYPE_BITS-1:0]   req_type;
    module_id_t             module_id;
    logic                   out_valid;
    logic                   out_ready;
    logic [STATUS_BITS-1:0] status;
    module_id_t             current_owner;
    logic                   was_owner;

    ownership_tracker sb = new();
    bit tx_gaps;
    bit rx_calm;
    bit long_stall_req;
    int cycles;

    priority_ownership_arbiter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .module_id     (module_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .current_owner (current_owner),
        .was_owner     (was_owner)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_item(req_type, module_id);
            if (out_valid && out_ready)
                sb.check_result(status, current_owner, was_owner);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [TYPE_BITS-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return REQ_REQUEST;
        if (r < 52)
            return REQ_RELEASE;
        if (r < 77)
            return REQ_TICK;
        if (r < 85)
            return REQ_SUPPRESS;
        if (r < 95)
            return REQ_ENABLE;
        return TYPE_BITS'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    endfunction

    function automatic module_id_t pick_id();
        int r;
        module_id_t one_hot;
        r = $urandom_range(0, 99);
        one_hot = '0;
        one_hot[$urandom_range(0, MODULE_BITS - 1)] = 1'b1;
        if (r < 70)
            return one_hot;
        if (r < 78)
            return '0;
        if (r < 84)
            return '1;
        return module_id_t'($urandom);
    endfunction

    task automatic offer_beat(logic [TYPE_BITS-1:0] kind, module_id_t mod);
        int gap;
        in_valid  <= 1'b1;
        req_type  <= kind;
        module_id <= mod;
        do
            @(posedge clk);
        while (!in_ready);
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hold(hold_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_hold(v);
    endtask

    // receiver: random backpressure, calm stretches, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else if (rx_calm || $urandom_range(0, 99) < 65)
            begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 30);
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin
        int p;
        int i;
        hold_t plan [8];
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        req_type       = REQ_REQUEST;
        module_id      = '0;
        out_ready      = 1'b0;
        cycles         = 0;
        tx_gaps        = 1'b1;
        rx_calm        = 1'b0;
        long_stall_req = 1'b0;
        plan = '{8'd0, 8'd255, 8'd2, 8'd5, 8'd1, 8'd3, 8'd255, 8'd4};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed, hold_ticks at its reset value
        offer_beat(REQ_REQUEST, 16'h0000);
        offer_beat(REQ_REQUEST, 16'h0001);
        offer_beat(REQ_REQUEST, 16'h8000);
        offer_beat(REQ_REQUEST, 16'h0008);
        offer_beat(REQ_RELEASE, 16'h0008);
        offer_beat(REQ_TICK, 16'h0000);
        offer_beat(REQ_REQUEST, 16'h8000);
        offer_beat(REQ_SUPPRESS, 16'h8000);
        offer_beat(REQ_REQUEST, 16'h8000);
        offer_beat(REQ_ENABLE, 16'h8000);
        offer_beat(REQ_REQUEST, 16'hFFFF);
        offer_beat(REQ_RELEASE, 16'hFFFF);
        offer_beat(REQ_SPARE_FIRST, 16'h1234);
        offer_beat(REQ_SPARE_LAST, 16'hFFFF);
        drain();

        // directed, short hold so the owner lapses
        write_hold(8'd1);
        offer_beat(REQ_REQUEST, 16'h4000);
        offer_beat(REQ_TICK, 16'h0000);
        offer_beat(REQ_TICK, 16'hFFFF);
        offer_beat(REQ_SUPPRESS, 16'h0002);
        offer_beat(REQ_REQUEST, 16'h0002);
        offer_beat(REQ_REQUEST, 16'h0010);
        offer_beat(REQ_ENABLE, 16'hFFFF);
        offer_beat(REQ_RELEASE, 16'h0000);
        offer_beat(REQ_SUPPRESS, 16'h0000);
        offer_beat(REQ_REQUEST, 16'h0010);
        offer_beat(REQ_REQUEST, 16'h0001);

        for (p = 0; p < 8; p++)
        begin
            drain();
            write_hold((p == 7) ? hold_t'($urandom_range(0, 15)) : plan[p]);
            tx_gaps = (p % 2) != 0;
            rx_calm = (p % 3) == 0;
            if (p == 2)
                long_stall_req = 1'b1;
            for (i = 0; i < PHASE_BEATS; i++)
                offer_beat(pick_kind(), pick_id());
        end
        drain();
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/poa_pkg.sv
design/poa_in_stage.sv
design/poa_engine.sv
design/poa_out_stage.sv
design/priority_ownership_arbiter_core.sv
bench/priority_ownership_arbiter_core_test.sv
